>>> hw/rtl/tspes_pkg.sv
package tspes_pkg;

    localparam int unsigned PID_W       = 13;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] PKT_LEN      = 8'd188;
    localparam logic [7:0] LAST_POS     = 8'd187;
    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] POS_PID_HI   = 8'd1;
    localparam logic [7:0] POS_PID_LO   = 8'd2;
    localparam logic [7:0] POS_ADAPT    = 8'd3;
    localparam logic [7:0] POS_ADAPT_LEN = 8'd4;
    localparam logic [7:0] HDR_LAST_REL = 8'd8;
    localparam logic [7:0] START_CODE_0 = 8'h00;
    localparam logic [7:0] START_CODE_2 = 8'h01;

    localparam logic [8:0] PLAIN_OFFSET = 9'd4;
    localparam logic [8:0] ADAPT_BASE   = 9'd5;
    localparam logic [8:0] PES_MAX_OFF  = 9'd179;

    localparam logic [9:0] PENDING      = 10'd1023;

    localparam logic [1:0] PHASE_DONE   = 2'd3;
    localparam logic [1:0] PHASE_LAST   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] es_byte;
        logic       packet_last;
    } t_out_item;

    // A command emits zeros leading start-code bytes, then the item itself.
    typedef struct packed {
        logic [1:0] zeros;
        t_out_item  item;
    } t_cmd;

endpackage

>>> hw/rtl/tspes_front.sv
module tspes_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tspes_pkg::PID_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  tspes_pkg::t_in_item           i_in_data,
    output logic                          o_in_stall,
    input  logic                          i_full,
    output logic                          o_push,
    output tspes_pkg::t_cmd               o_cmd
);

    logic [tspes_pkg::PID_W-1:0] r_target_pid;
    logic [7:0] r_pos, n_pos;
    logic       r_acc, n_acc;
    logic       r_us, n_us;
    logic [1:0] r_ac, n_ac;
    logic [4:0] r_pid_hi, n_pid_hi;
    logic [8:0] r_poff, n_poff;
    logic [9:0] r_sso, n_sso;
    logic [1:0] r_phase, n_phase;

    logic       accept;
    logic [7:0] pos;
    logic [7:0] b;
    logic [7:0] rel;
    logic [7:0] want;
    logic       last;
    logic       set_off;
    logic [8:0] off;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign b          = i_in_data.data_byte;

    always_comb begin
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_us     = r_us;
        n_ac     = r_ac;
        n_pid_hi = r_pid_hi;
        n_poff   = r_poff;
        n_sso    = r_sso;
        n_phase  = r_phase;
        o_push   = 1'b0;
        o_cmd    = '0;
        set_off  = 1'b0;
        off      = '0;
        rel      = '0;
        want     = tspes_pkg::START_CODE_0;
        pos      = i_in_data.packet_start ? 8'd0 : r_pos;
        last     = (pos == tspes_pkg::LAST_POS);
        if (accept) begin
            if (i_in_data.packet_start) begin
                n_acc   = 1'b0;
                n_phase = '0;
                n_sso   = tspes_pkg::PENDING;
            end
            if (pos < tspes_pkg::PKT_LEN) begin
                priority if (pos == 8'd0) begin
                    n_acc = (b == tspes_pkg::SYNC_BYTE);
                end else if (pos == tspes_pkg::POS_PID_HI) begin
                    n_us     = b[6];
                    n_pid_hi = b[4:0];
                end else if (pos == tspes_pkg::POS_PID_LO) begin
                    if ({r_pid_hi, b} != r_target_pid) begin
                        n_acc = 1'b0;
                    end
                end else if (pos == tspes_pkg::POS_ADAPT) begin
                    n_ac = b[5:4];
                    if (!b[4]) begin
                        n_acc = 1'b0;
                    end else if (!b[5]) begin
                        set_off = 1'b1;
                        off     = tspes_pkg::PLAIN_OFFSET;
                    end
                end else begin
                    if (pos == tspes_pkg::POS_ADAPT_LEN && r_ac[1]) begin
                        set_off = 1'b1;
                        off     = tspes_pkg::ADAPT_BASE + {1'b0, b};
                    end
                end

                if (set_off) begin
                    n_poff = off;
                    if (off >= {1'b0, tspes_pkg::PKT_LEN}) begin
                        n_acc = 1'b0;
                        n_sso = tspes_pkg::PENDING;
                    end else if (r_us && off <= tspes_pkg::PES_MAX_OFF) begin
                        n_sso   = tspes_pkg::PENDING;
                        n_phase = '0;
                    end else begin
                        n_sso = {1'b0, off};
                    end
                end

                if (pos >= tspes_pkg::POS_ADAPT_LEN && n_acc && {1'b0, pos} >= n_poff) begin
                    rel = pos - n_poff[7:0];
                    if (n_sso == tspes_pkg::PENDING) begin
                        if (n_phase != tspes_pkg::PHASE_DONE) begin
                            want = (n_phase == tspes_pkg::PHASE_LAST) ?
                                   tspes_pkg::START_CODE_2 : tspes_pkg::START_CODE_0;
                            if (b == want) begin
                                n_phase = n_phase + 2'd1;
                            end else begin
                                // The bytes already matched were all zero.
                                o_push                 = 1'b1;
                                o_cmd.zeros            = n_phase;
                                o_cmd.item.es_byte     = b;
                                o_cmd.item.packet_last = last;
                                n_sso                  = {2'b0, pos} + 10'd1;
                            end
                        end else if (rel == tspes_pkg::HDR_LAST_REL) begin
                            n_sso = {2'b0, pos} + 10'd1 + {2'b0, b};
                        end
                    end else if ({2'b0, pos} >= n_sso) begin
                        o_push                 = 1'b1;
                        o_cmd.item.es_byte     = b;
                        o_cmd.item.packet_last = last;
                    end
                end
                n_pos = pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid <= '1;
            r_pos        <= tspes_pkg::PKT_LEN;
            r_acc        <= 1'b0;
            r_us         <= 1'b0;
            r_ac         <= '0;
            r_pid_hi     <= '0;
            r_poff       <= '0;
            r_sso        <= tspes_pkg::PENDING;
            r_phase      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target_pid <= i_cfg_wr_data;
            end
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_us     <= n_us;
            r_ac     <= n_ac;
            r_pid_hi <= n_pid_hi;
            r_poff   <= n_poff;
            r_sso    <= n_sso;
            r_phase  <= n_phase;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= tspes_pkg::PKT_LEN)
        else $error("byte position out of range");

    a_push_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && pos >= tspes_pkg::POS_ADAPT_LEN && n_acc))
        else $error("command pushed outside an accepted payload");

endmodule

>>> hw/rtl/tspes_queue.sv
module tspes_queue #(
    parameter int unsigned DEPTH = tspes_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tspes_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tspes_pkg::t_cmd o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tspes_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

>>> hw/rtl/tspes_back.sv
module tspes_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  tspes_pkg::t_cmd      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tspes_pkg::t_out_item o_out_data
);

    logic                 r_out_valid, n_out_valid;
    tspes_pkg::t_out_item r_out, n_out;
    logic [1:0]           r_done, n_done;
    logic                 load;

    assign load        = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_done      = r_done;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = !i_empty;
            if (!i_empty) begin
                if (r_done != i_head.zeros) begin
                    n_out.es_byte     = tspes_pkg::START_CODE_0;
                    n_out.packet_last = 1'b0;
                    n_done            = r_done + 2'd1;
                end else begin
                    n_out  = i_head.item;
                    n_done = '0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
        end
    end

    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != 2'd0) |-> (!i_empty && r_done <= i_head.zeros))
        else $error("leading zero count ran past its command");

endmodule

>>> hw/rtl/ts_pes_payload_extractor.sv
// Channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_in_data  (data_byte, packet_start)
// output   | o_out_valid  | i_out_stall  | o_out_data (es_byte, packet_last)
// config   | i_cfg_wr_en  | none         | i_cfg_wr_data (target_pid)
//
// One transport byte is accepted per cycle while the command queue has room.
// A byte yields at most one queued command; a start-code mismatch expands into up
// to three result transactions, delivered one per cycle from the output register
// when not stalled. Reset is synchronous and active low. Output stall backs up the
// queue, and the input stalls only when the queue is full.
module ts_pes_payload_extractor #(
    parameter int unsigned QUEUE_DEPTH = tspes_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tspes_pkg::PID_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tspes_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tspes_pkg::t_out_item          o_out_data
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    tspes_pkg::t_cmd cmd;
    tspes_pkg::t_cmd head;

    tspes_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    tspes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    tspes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sim/ts_pes_payload_extractor_tb.sv
`timescale 1ns / 100ps

module ts_pes_payload_extractor_tb;

    localparam int NO_CFG      = -1;
    localparam int UNTYPED     = -1;
    localparam int AFC_NONE    = 0;
    localparam int AFC_PAYLOAD = 1;
    localparam int AFC_ADAPT   = 2;
    localparam int AFC_BOTH    = 3;
    localparam int MODE_RAW    = 0;
    localparam int MODE_PES    = 1;
    localparam int MODE_MISS0  = 2;
    localparam int MODE_MISS1  = 3;
    localparam int MODE_MISS2  = 4;
    localparam int PES_HDR_MIN = 9;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 16;

    typedef struct packed {
        int cfg;
        int pre;
        int sync_ok;
        int pid;
        int pusi;
        int afc;
        int alen;
        int mode;
        int extra;
        int len;
        int exp_n;
    } t_pkt_spec;

    // Columns: cfg, stray, sync, pid, pusi, afc, adapt length, payload mode, header
    // extension, length, emitted byte count (the tail of the packet).
    t_pkt_spec directed_rows [15] = '{
        '{NO_CFG, 3, 1, 8191, 0, AFC_PAYLOAD,   0, MODE_RAW,    0,  20,      16},
        '{NO_CFG, 0, 1, 8191, 0, AFC_ADAPT,     0, MODE_RAW,    0,   8,       0},
        '{NO_CFG, 0, 1, 8191, 0, AFC_NONE,      0, MODE_RAW,    0,   8,       0},
        '{NO_CFG, 0, 0, 8191, 0, AFC_PAYLOAD,   0, MODE_RAW,    0,   8,       0},
        '{NO_CFG, 0, 1, 8190, 0, AFC_PAYLOAD,   0, MODE_RAW,    0,   8,       0},
        '{0,      0, 1,    0, 0, AFC_BOTH,      0, MODE_RAW,    0,  20, UNTYPED},
        '{NO_CFG, 0, 1,    0, 0, AFC_BOTH,    183, MODE_RAW,    0,  10,       0},
        '{NO_CFG, 0, 1,    0, 0, AFC_BOTH,    255, MODE_RAW,    0,   8,       0},
        '{NO_CFG, 0, 1,    0, 1, AFC_PAYLOAD,   0, MODE_PES,    3,  24, UNTYPED},
        '{NO_CFG, 0, 1,    0, 1, AFC_PAYLOAD,   0, MODE_MISS0,  0,  12,       8},
        '{NO_CFG, 0, 1,    0, 1, AFC_PAYLOAD,   0, MODE_MISS1,  0,  12,       8},
        '{NO_CFG, 0, 1,    0, 1, AFC_PAYLOAD,   0, MODE_MISS2,  0,  12,       8},
        '{4660,   0, 1, 4660, 1, AFC_PAYLOAD,   0, MODE_PES,  255,  20,       0},
        '{NO_CFG, 0, 1, 4660, 1, AFC_PAYLOAD,   0, MODE_PES,    0,   6,       0},
        '{NO_CFG, 0, 1, 4660, 1, AFC_BOTH,    176, MODE_PES,    0, 191,       7}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [tspes_pkg::PID_W-1:0] i_cfg_wr_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    tspes_pkg::t_in_item         i_in_data;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    tspes_pkg::t_out_item        o_out_data;

    tspes_pkg::t_out_item        expected_es [$];
    logic [7:0]                  pkt_bytes [$];
    int                          errors = 0;
    int                          idle_cycles = 0;
    int                          burst_left = 0;
    int                          stall_mode = 0;
    int                          stall_cyc = 0;
    bit                          typed_row = 1'b0;

    logic [tspes_pkg::PID_W-1:0] target_pid_q = 13'h1fff;
    int                          pkt_pos = tspes_pkg::PKT_LEN;
    bit                          pkt_ok = 1'b0;
    bit                          pusi_flag = 1'b0;
    logic [1:0]                  afc_bits = 2'd0;
    logic [4:0]                  pid_hi = 5'd0;
    int                          pay_off = 0;
    int                          es_start = tspes_pkg::PENDING;
    logic [1:0]                  sc_phase = 2'd0;
    logic [7:0]                  sc_held [2];

    ts_pes_payload_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic put_es(input logic [7:0] b, input bit last);
        tspes_pkg::t_out_item r;
        r.es_byte = b;
        r.packet_last = last;
        if (!typed_row) begin
            expected_es = {expected_es, r};
        end
    endtask

    task automatic set_payload_offset(input int off);
        pay_off = off;
        if (off >= tspes_pkg::PKT_LEN) begin
            pkt_ok = 1'b0;
            es_start = tspes_pkg::PENDING;
        end else if (pusi_flag && off <= tspes_pkg::PES_MAX_OFF) begin
            es_start = tspes_pkg::PENDING;
            sc_phase = 2'd0;
        end else begin
            es_start = off;
        end
    endtask

    task automatic extract_es_byte(input tspes_pkg::t_in_item it);
        logic [7:0] b;
        int p;
        bit last;
        b = it.data_byte;
        if (it.packet_start) begin
            pkt_pos = 0;
            pkt_ok = 1'b0;
            sc_phase = 2'd0;
            es_start = tspes_pkg::PENDING;
        end
        if (pkt_pos >= tspes_pkg::PKT_LEN) begin
            return;
        end
        p = pkt_pos;
        last = (p == tspes_pkg::LAST_POS);
        if (p == 0) begin
            pkt_ok = (b == tspes_pkg::SYNC_BYTE);
        end else if (p == tspes_pkg::POS_PID_HI) begin
            pusi_flag = b[6];
            pid_hi = b[4:0];
        end else if (p == tspes_pkg::POS_PID_LO) begin
            if ({pid_hi, b} != target_pid_q) begin
                pkt_ok = 1'b0;
            end
        end else if (p == tspes_pkg::POS_ADAPT) begin
            afc_bits = b[5:4];
            if (!afc_bits[0]) begin
                pkt_ok = 1'b0;
            end else if (!afc_bits[1]) begin
                set_payload_offset(tspes_pkg::PLAIN_OFFSET);
            end
        end else begin
            if (p == tspes_pkg::POS_ADAPT_LEN && afc_bits[1]) begin
                set_payload_offset(tspes_pkg::ADAPT_BASE + b);
            end
            if (pkt_ok && p >= pay_off) begin
                if (es_start == tspes_pkg::PENDING) begin
                    if (sc_phase != tspes_pkg::PHASE_DONE) begin
                        if (b == ((sc_phase == tspes_pkg::PHASE_LAST) ?
                                  tspes_pkg::START_CODE_2 : tspes_pkg::START_CODE_0)) begin
                            if (sc_phase != tspes_pkg::PHASE_LAST) begin
                                sc_held[sc_phase[0]] = b;
                            end
                            sc_phase = sc_phase + 2'd1;
                        end else begin
                            for (int i = 0; i < sc_phase; i++) begin
                                put_es(sc_held[i], 1'b0);
                            end
                            put_es(b, last);
                            es_start = p + 1;
                        end
                    end else if (p - pay_off == tspes_pkg::HDR_LAST_REL) begin
                        es_start = pay_off + PES_HDR_MIN + b;
                    end
                end else if (p >= es_start) begin
                    put_es(b, last);
                end
            end
        end
        pkt_pos = p + 1;
    endtask

    task automatic build_packet(input t_pkt_spec s);
        int off;
        int rel;
        logic [7:0] v;
        pkt_bytes.delete();
        off = ((s.afc & AFC_ADAPT) != 0) ? tspes_pkg::ADAPT_BASE + s.alen
                                         : tspes_pkg::PLAIN_OFFSET;
        for (int k = 0; k < s.len; k++) begin
            v = 8'($urandom_range(0, 255));
            rel = k - off;
            if (k == 0) begin
                v = s.sync_ok ? tspes_pkg::SYNC_BYTE
                              : (tspes_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255)));
            end else if (k == tspes_pkg::POS_PID_HI) begin
                v = {v[7], s.pusi[0], v[5], s.pid[12:8]};
            end else if (k == tspes_pkg::POS_PID_LO) begin
                v = s.pid[7:0];
            end else if (k == tspes_pkg::POS_ADAPT) begin
                v = {v[7:6], s.afc[1:0], v[3:0]};
            end else if (k == tspes_pkg::POS_ADAPT_LEN && (s.afc & AFC_ADAPT) != 0) begin
                v = s.alen[7:0];
            end else if (rel >= 0 && k < tspes_pkg::PKT_LEN) begin
                case (s.mode)
                    MODE_PES: begin
                        if (rel < 2) begin
                            v = tspes_pkg::START_CODE_0;
                        end else if (rel == 2) begin
                            v = tspes_pkg::START_CODE_2;
                        end else if (rel == tspes_pkg::HDR_LAST_REL) begin
                            v = s.extra[7:0];
                        end
                    end
                    MODE_MISS0: begin
                        if (rel == 0) begin
                            v = 8'($urandom_range(1, 255));
                        end
                    end
                    MODE_MISS1: begin
                        if (rel == 0) begin
                            v = tspes_pkg::START_CODE_0;
                        end else if (rel == 1) begin
                            v = 8'($urandom_range(1, 255));
                        end
                    end
                    MODE_MISS2: begin
                        if (rel < 2) begin
                            v = tspes_pkg::START_CODE_0;
                        end else if (rel == 2) begin
                            v = 8'($urandom_range(0, 254));
                            if (v >= tspes_pkg::START_CODE_2) begin
                                v = v + 8'd1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pkt_bytes = {pkt_bytes, v};
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [7:0] b, input bit start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{data_byte: b, packet_start: start};
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic write_target_pid(input int pid);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_es.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= pid[tspes_pkg::PID_W-1:0];
        target_pid_q = pid[tspes_pkg::PID_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_packet(input t_pkt_spec s, output int sent);
        tspes_pkg::t_out_item r;
        int eff;
        sent = 0;
        if (s.cfg != NO_CFG) begin
            write_target_pid(s.cfg);
        end
        build_packet(s);
        typed_row = (s.exp_n != UNTYPED);
        if (typed_row) begin
            eff = (s.len < tspes_pkg::PKT_LEN) ? s.len : tspes_pkg::PKT_LEN;
            for (int k = eff - s.exp_n; k < eff; k++) begin
                r.es_byte = pkt_bytes[k];
                r.packet_last = (k == tspes_pkg::LAST_POS);
                expected_es = {expected_es, r};
            end
        end
        repeat (s.pre) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
            sent++;
        end
        foreach (pkt_bytes[k]) begin
            send_item(pkt_bytes[k], k == 0);
            sent++;
        end
    endtask

    always @(negedge i_clk) begin
        stall_cyc++;
        if (stall_cyc % 97 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_cyc % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        tspes_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                extract_es_byte(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_es.size() == 0) begin
                    flag_error($sformatf("unexpected transaction es_byte %02h last %0b",
                                         o_out_data.es_byte, o_out_data.packet_last));
                end else begin
                    want = expected_es.pop_front();
                    if (o_out_data.es_byte !== want.es_byte) begin
                        flag_error($sformatf("es_byte %02h, expected %02h",
                                             o_out_data.es_byte, want.es_byte));
                    end
                    if (o_out_data.packet_last !== want.packet_last) begin
                        flag_error($sformatf("packet_last %0b, expected %0b on byte %02h",
                                             o_out_data.packet_last, want.packet_last,
                                             want.es_byte));
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ts_pes_payload_extractor_tb failed");
                $finish;
            end
        end
    end

    initial begin
        t_pkt_spec s;
        int sent;
        int phase_bytes;
        int r;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_packet(directed_rows[i], sent);
        end
        typed_row = 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_target_pid(8191);
                2: write_target_pid(0);
                default: write_target_pid($urandom_range(1, 8190));
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                s.cfg = NO_CFG;
                s.exp_n = UNTYPED;
                s.pre = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                s.sync_ok = ($urandom_range(0, 9) != 0);
                s.pid = ($urandom_range(0, 6) != 0) ? int'(target_pid_q)
                                                    : $urandom_range(0, 8191);
                s.pusi = $urandom_range(0, 1);
                r = $urandom_range(0, 19);
                s.afc = (r < 10) ? AFC_PAYLOAD : (r < 17) ? AFC_BOTH :
                        (r < 18) ? AFC_NONE : AFC_ADAPT;
                r = $urandom_range(0, 9);
                s.alen = (r < 6) ? $urandom_range(0, 8) :
                         (r < 9) ? $urandom_range(170, 190) : $urandom_range(0, 255);
                r = $urandom_range(0, 9);
                s.mode = (r < 5) ? MODE_PES : (r == 5) ? MODE_MISS0 :
                         (r == 6) ? MODE_MISS1 : (r == 7) ? MODE_MISS2 : MODE_RAW;
                s.extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 6);
                s.len = ($urandom_range(0, 11) == 0) ? $urandom_range(188, 191)
                                                     : $urandom_range(5, 24);
                send_packet(s, sent);
                phase_bytes += sent;
            end
        end

        i_in_valid <= 1'b0;
        while (expected_es.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (expected_es.size() != 0) begin
            flag_error($sformatf("%0d expected transactions never arrived",
                                 expected_es.size()));
        end
        if (errors == 0) begin
            $display("ts_pes_payload_extractor_tb passed");
        end else begin
            $display("ts_pes_payload_extractor_tb failed");
        end
        $finish;
    end

endmodule

>>> ts_pes_payload_extractor.f
hw/rtl/tspes_pkg.sv
hw/rtl/tspes_front.sv
hw/rtl/tspes_queue.sv
hw/rtl/tspes_back.sv
hw/rtl/ts_pes_payload_extractor.sv
sim/ts_pes_payload_extractor_tb.sv
